// ===== design/mmq_pkg.sv =====
`default_nettype none
package mmq_pkg;

   localparam int LEN_W = 7;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_LATEST = 2'd2;
   localparam logic [1:0] OP_OVR    = 2'd3;

   localparam logic [2:0] CSR_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_MAXLEN0 = 3'd1;
   localparam logic [2:0] CSR_MAXLEN3 = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_COPY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             ok;
      logic [7:0]       data;
      logic             byte_valid;
      logic [LEN_W-1:0] length;
      logic             flag;
      logic             last;
   } rsp_type;

   function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage
`default_nettype wire

// ===== design/multi_message_queue.sv =====
// push and overrun read: result registered in the cycle after accept; new items taken back to back
// pop with a message: length read, byte read, then result bytes one per cycle while not stalled
// pop latest with a message to take: first copies the stored message into the held store
// a new item is taken once the last result of the previous one is loaded and the output is free
// reset clears pointers, counts, flags, push state and enables; message stores are not cleared
`default_nettype none
module multi_message_queue #(
   parameter int QUEUES      = 4,
   parameter int SLOTS       = 8,
   parameter int MAX_MESSAGE = 64
) (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_valid,
   output logic             req_stall,
   input  wire  logic [1:0] req_opcode,
   input  wire  logic [2:0] req_queue,
   input  wire  logic [7:0] req_data_byte,
   input  wire  logic       req_byte_present,
   input  wire  logic       req_last_byte,
   input  wire  logic [6:0] req_read_limit,
   output logic             rsp_valid,
   input  wire  logic       rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic             rsp_ok,
   output logic [7:0]       rsp_data_byte_out,
   output logic             rsp_byte_valid,
   output logic [6:0]       rsp_length,
   output logic             rsp_overrun_flag,
   output logic             rsp_last,
   input  wire  logic       csr_write,
   input  wire  logic [2:0] csr_index,
   input  wire  logic [6:0] csr_data
);
   import mmq_pkg::*;

   localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int SW  = $clog2(SLOTS);
   localparam int FW  = $clog2(SLOTS + 1);
   localparam int AW  = $clog2(QUEUES * SLOTS * MAX_MESSAGE);
   localparam int LAW = $clog2(QUEUES * SLOTS);
   localparam int HW  = (QUEUES * MAX_MESSAGE > 1) ? $clog2(QUEUES * MAX_MESSAGE) : 1;
   localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_MESSAGE);

   logic [3:0]       enable_ff;
   logic [LEN_W-1:0] maxlen_ff [4];

   logic [SW-1:0]    wslot_ff [QUEUES];
   logic [SW-1:0]    wslot_in [QUEUES];
   logic [SW-1:0]    rslot_ff [QUEUES];
   logic [SW-1:0]    rslot_in [QUEUES];
   logic [FW-1:0]    fill_ff  [QUEUES];
   logic [FW-1:0]    fill_in  [QUEUES];
   logic             ovr_ff   [QUEUES];
   logic             ovr_in   [QUEUES];
   logic [LEN_W-1:0] hlen_ff  [QUEUES];
   logic [LEN_W-1:0] hlen_in  [QUEUES];

   logic             push_busy_ff, push_busy_in;
   logic             push_ok_ff, push_ok_in;
   logic [LEN_W-1:0] push_cnt_ff, push_cnt_in;
   logic [QW-1:0]    push_q_ff, push_q_in;

   state_type        state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [LEN_W-1:0] lim_ff, lim_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [LEN_W-1:0] e_ff, e_in;
   logic [LEN_W-1:0] c_ff, c_in;
   logic             wpend_ff, wpend_in;
   logic [LEN_W-1:0] widx_ff, widx_in;
   logic             src_held_ff, src_held_in;

   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic             load;
   logic             out_free;

   logic             msg_we, msg_re, len_we, len_re, held_we, held_re;
   logic [AW-1:0]    msg_waddr, msg_raddr;
   logic [7:0]       msg_wdata, msg_rdata, held_wdata, held_rdata;
   logic [LAW-1:0]   len_waddr, len_raddr;
   logic [LEN_W-1:0] len_wdata, len_rdata;
   logic [HW-1:0]    held_waddr, held_raddr;

   mmq_store #(.AW(AW), .LAW(LAW)) u_store (
      .clock     (clock),
      .msg_we    (msg_we),
      .msg_waddr (msg_waddr),
      .msg_wdata (msg_wdata),
      .msg_re    (msg_re),
      .msg_raddr (msg_raddr),
      .msg_rdata (msg_rdata),
      .len_we    (len_we),
      .len_waddr (len_waddr),
      .len_wdata (len_wdata),
      .len_re    (len_re),
      .len_raddr (len_raddr),
      .len_rdata (len_rdata)
   );

   mmq_held #(.HW(HW)) u_held (
      .clock (clock),
      .we    (held_we),
      .waddr (held_waddr),
      .wdata (held_wdata),
      .re    (held_re),
      .raddr (held_raddr),
      .rdata (held_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            maxlen_ff[i] <= LEN_W'(64);
         end
      end else if (csr_write) begin
         if (csr_index == CSR_ENABLE) begin
            enable_ff <= csr_data[3:0];
         end else if (csr_index >= CSR_MAXLEN0 && csr_index <= CSR_MAXLEN3) begin
            maxlen_ff[2'(csr_index - CSR_MAXLEN0)] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         push_busy_ff <= 1'b0;
         push_ok_ff   <= 1'b0;
         push_cnt_ff  <= '0;
         push_q_ff    <= '0;
         wpend_ff     <= 1'b0;
         for (int i = 0; i < QUEUES; i++) begin
            wslot_ff[i] <= '0;
            rslot_ff[i] <= '0;
            fill_ff[i]  <= '0;
            ovr_ff[i]   <= 1'b0;
            hlen_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         push_busy_ff <= push_busy_in;
         push_ok_ff   <= push_ok_in;
         push_cnt_ff  <= push_cnt_in;
         push_q_ff    <= push_q_in;
         wpend_ff     <= wpend_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         fill_ff      <= fill_in;
         ovr_ff       <= ovr_in;
         hlen_ff      <= hlen_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      q_ff        <= q_in;
      slot_ff     <= slot_in;
      lim_ff      <= lim_in;
      len_ff      <= len_in;
      n_ff        <= n_in;
      e_ff        <= e_in;
      c_ff        <= c_in;
      widx_ff     <= widx_in;
      src_held_ff <= src_held_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      logic             vq;
      logic             en;
      logic             take;
      logic [QW-1:0]    qi;
      logic [QW-1:0]    p_q;
      logic             p_ok;
      logic [LEN_W-1:0] p_cnt;
      logic [LEN_W-1:0] l;
      logic [LEN_W-1:0] n;

      state_in     = state_ff;
      kind_in      = kind_ff;
      q_in         = q_ff;
      slot_in      = slot_ff;
      lim_in       = lim_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      c_in         = c_ff;
      wpend_in     = wpend_ff;
      widx_in      = widx_ff;
      src_held_in  = src_held_ff;
      push_busy_in = push_busy_ff;
      push_ok_in   = push_ok_ff;
      push_cnt_in  = push_cnt_ff;
      push_q_in    = push_q_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      fill_in      = fill_ff;
      ovr_in       = ovr_ff;
      hlen_in      = hlen_ff;
      load         = 1'b0;
      rsp_in       = '0;
      msg_we       = 1'b0;
      msg_waddr    = '0;
      msg_wdata    = req_data_byte;
      msg_re       = 1'b0;
      msg_raddr    = '0;
      len_we       = 1'b0;
      len_waddr    = '0;
      len_wdata    = '0;
      len_re       = 1'b0;
      len_raddr    = '0;
      held_we      = 1'b0;
      held_waddr   = '0;
      held_wdata   = msg_rdata;
      held_re      = 1'b0;
      held_raddr   = '0;

      qi    = QW'(req_queue);
      vq    = req_queue < 3'(QUEUES);
      en    = enable_ff[2'(qi)];
      take  = vq && en && (fill_ff[qi] != '0);
      p_q   = push_q_ff;
      p_ok  = push_ok_ff;
      p_cnt = push_cnt_ff;
      l     = '0;
      n     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               case (req_opcode)
                  OP_PUSH: begin
                     if (!push_busy_ff) begin
                        p_q   = qi;
                        p_cnt = '0;
                        p_ok  = vq && en && (fill_ff[qi] != FW'(SLOTS));
                        if (vq && en && (fill_ff[qi] == FW'(SLOTS))) begin
                           ovr_in[qi] = 1'b1;
                        end
                     end
                     if (p_ok && req_byte_present &&
                         p_cnt < min_len(maxlen_ff[2'(p_q)], MAXL)) begin
                        msg_we    = 1'b1;
                        msg_waddr = AW'((int'(p_q) * SLOTS + int'(wslot_ff[p_q])) * MAX_MESSAGE
                                        + int'(p_cnt));
                        p_cnt     = p_cnt + LEN_W'(1);
                     end
                     if (req_last_byte) begin
                        load          = 1'b1;
                        rsp_in.kind   = OP_PUSH;
                        rsp_in.last   = 1'b1;
                        push_busy_in  = 1'b0;
                        push_ok_in    = 1'b0;
                        push_cnt_in   = '0;
                        push_q_in     = p_q;
                        if (p_ok) begin
                           len_we        = 1'b1;
                           len_waddr     = LAW'(int'(p_q) * SLOTS + int'(wslot_ff[p_q]));
                           len_wdata     = p_cnt;
                           wslot_in[p_q] = (wslot_ff[p_q] == SW'(SLOTS - 1)) ? '0 :
                                           wslot_ff[p_q] + SW'(1);
                           fill_in[p_q]  = fill_ff[p_q] + FW'(1);
                           rsp_in.ok     = 1'b1;
                           rsp_in.length = p_cnt;
                        end
                     end else begin
                        push_busy_in = 1'b1;
                        push_ok_in   = p_ok;
                        push_cnt_in  = p_cnt;
                        push_q_in    = p_q;
                     end
                  end
                  OP_POP, OP_LATEST: begin
                     kind_in = req_opcode;
                     q_in    = qi;
                     lim_in  = req_read_limit;
                     if (!vq || (req_opcode == OP_POP && !take)) begin
                        load        = 1'b1;
                        rsp_in.kind = req_opcode;
                        rsp_in.last = 1'b1;
                     end else if (take) begin
                        len_re       = 1'b1;
                        len_raddr    = LAW'(int'(qi) * SLOTS + int'(rslot_ff[qi]));
                        slot_in      = rslot_ff[qi];
                        rslot_in[qi] = (rslot_ff[qi] == SW'(SLOTS - 1)) ? '0 :
                                       rslot_ff[qi] + SW'(1);
                        fill_in[qi]  = fill_ff[qi] - FW'(1);
                        state_in     = ST_LEN;
                     end else begin
                        n           = min_len(hlen_ff[qi], req_read_limit);
                        n_in        = n;
                        e_in        = '0;
                        src_held_in = 1'b1;
                        if (n != '0) begin
                           held_re    = 1'b1;
                           held_raddr = HW'(int'(qi) * MAX_MESSAGE);
                        end
                        state_in = ST_EMIT;
                     end
                  end
                  OP_OVR: begin
                     load        = 1'b1;
                     rsp_in.kind = OP_OVR;
                     rsp_in.last = 1'b1;
                     if (vq) begin
                        rsp_in.ok   = 1'b1;
                        rsp_in.flag = ovr_ff[qi];
                        ovr_in[qi]  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LEN: begin
            l = min_len(len_rdata, MAXL);
            if (kind_ff == OP_POP) begin
               n           = min_len(l, lim_ff);
               n_in        = n;
               e_in        = '0;
               src_held_in = 1'b0;
               if (n != '0) begin
                  msg_re    = 1'b1;
                  msg_raddr = AW'((int'(q_ff) * SLOTS + int'(slot_ff)) * MAX_MESSAGE);
               end
               state_in = ST_EMIT;
            end else begin
               len_in   = l;
               c_in     = '0;
               wpend_in = 1'b0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (wpend_ff) begin
               held_we    = 1'b1;
               held_waddr = HW'(int'(q_ff) * MAX_MESSAGE + int'(widx_ff));
            end
            if (c_ff < len_ff) begin
               msg_re    = 1'b1;
               msg_raddr = AW'((int'(q_ff) * SLOTS + int'(slot_ff)) * MAX_MESSAGE + int'(c_ff));
               c_in      = c_ff + LEN_W'(1);
               wpend_in  = 1'b1;
               widx_in   = c_ff;
            end else begin
               wpend_in = 1'b0;
               if (!wpend_ff) begin
                  hlen_in[q_ff] = len_ff;
                  n             = min_len(len_ff, lim_ff);
                  n_in          = n;
                  e_in          = '0;
                  src_held_in   = 1'b1;
                  if (n != '0) begin
                     held_re    = 1'b1;
                     held_raddr = HW'(int'(q_ff) * MAX_MESSAGE);
                  end
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_in.kind = kind_ff;
               rsp_in.ok   = 1'b1;
               if (n_ff == '0) begin
                  rsp_in.last = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_in.data       = src_held_ff ? held_rdata : msg_rdata;
                  rsp_in.byte_valid = 1'b1;
                  rsp_in.length     = n_ff;
                  rsp_in.last       = (e_ff + LEN_W'(1) == n_ff);
                  if (e_ff + LEN_W'(1) == n_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     e_in = e_ff + LEN_W'(1);
                     if (src_held_ff) begin
                        held_re    = 1'b1;
                        held_raddr = HW'(int'(q_ff) * MAX_MESSAGE + int'(e_ff) + 1);
                     end else begin
                        msg_re    = 1'b1;
                        msg_raddr = AW'((int'(q_ff) * SLOTS + int'(slot_ff)) * MAX_MESSAGE
                                        + int'(e_ff) + 1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_ok            = rsp_ff.ok;
   assign rsp_data_byte_out = rsp_ff.data;
   assign rsp_byte_valid    = rsp_ff.byte_valid;
   assign rsp_length        = rsp_ff.length;
   assign rsp_overrun_flag  = rsp_ff.flag;
   assign rsp_last          = rsp_ff.last;

endmodule
`default_nettype wire

// ===== design/mmq_store.sv =====
`default_nettype none
module mmq_store #(
   parameter int AW  = 11,
   parameter int LAW = 5
) (
   input  wire  logic                     clock,
   input  wire  logic                     msg_we,
   input  wire  logic [AW-1:0]            msg_waddr,
   input  wire  logic [7:0]               msg_wdata,
   input  wire  logic                     msg_re,
   input  wire  logic [AW-1:0]            msg_raddr,
   output logic       [7:0]               msg_rdata,
   input  wire  logic                     len_we,
   input  wire  logic [LAW-1:0]           len_waddr,
   input  wire  logic [mmq_pkg::LEN_W-1:0] len_wdata,
   input  wire  logic                     len_re,
   input  wire  logic [LAW-1:0]           len_raddr,
   output logic       [mmq_pkg::LEN_W-1:0] len_rdata
);
   import mmq_pkg::*;

   logic [7:0]       msg_mem [2**AW];
   logic [LEN_W-1:0] len_mem [2**LAW];
   logic [7:0]       msg_rdata_ff;
   logic [LEN_W-1:0] len_rdata_ff;

   always_ff @(posedge clock) begin
      if (msg_we) begin
         msg_mem[msg_waddr] <= msg_wdata;
      end
      if (msg_re) begin
         msg_rdata_ff <= msg_mem[msg_raddr];
      end
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (len_re) begin
         len_rdata_ff <= len_mem[len_raddr];
      end
   end

   assign msg_rdata = msg_rdata_ff;
   assign len_rdata = len_rdata_ff;

endmodule
`default_nettype wire

// ===== design/mmq_held.sv =====
`default_nettype none
module mmq_held #(
   parameter int HW = 8
) (
   input  wire  logic          clock,
   input  wire  logic          we,
   input  wire  logic [HW-1:0] waddr,
   input  wire  logic [7:0]    wdata,
   input  wire  logic          re,
   input  wire  logic [HW-1:0] raddr,
   output logic       [7:0]    rdata
);
   import mmq_pkg::*;

   logic [7:0] mem [2**HW];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== design/mmq_checker.sv =====
`default_nettype none
module mmq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_result_kind,
   input wire logic       rsp_ok,
   input wire logic [7:0] rsp_data_byte_out,
   input wire logic       rsp_byte_valid,
   input wire logic [6:0] rsp_length,
   input wire logic       rsp_overrun_flag,
   input wire logic       rsp_last
);
   import mmq_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte_out)
         && $stable(rsp_length) && $stable(rsp_last))
      else $error("stalled item changed");

   a_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_ok && rsp_length != 7'd0
         && (rsp_result_kind == OP_POP || rsp_result_kind == OP_LATEST))
      else $error("byte item without success");

   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> !rsp_byte_valid && rsp_length == 7'd0 && rsp_last)
      else $error("failed item carries data");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overrun_flag |-> rsp_result_kind == OP_OVR && rsp_last)
      else $error("overrun flag on wrong item");

   a_nobyte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last)
      else $error("non-byte item not last");

endmodule

bind multi_message_queue mmq_checker u_mmq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_ok            (rsp_ok),
   .rsp_data_byte_out (rsp_data_byte_out),
   .rsp_byte_valid    (rsp_byte_valid),
   .rsp_length        (rsp_length),
   .rsp_overrun_flag  (rsp_overrun_flag),
   .rsp_last          (rsp_last)
);
`default_nettype wire
